@@ rtl/bresenham_line_rasterizer_top_macros.svh @@
// ----------------------------------------------------------------------------
// Bresenham line rasterizer assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_RASTERIZER_TOP_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_TOP_MACROS_SVH

// Overlapping implication, checked out of reset.
`define BLR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line rasterizer check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define BLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line rasterizer check failed");

`endif

@@ rtl/blr_pkg.sv @@
// ----------------------------------------------------------------------------
// Bresenham line rasterizer package
// Widths, reset values, operation and register codes of the rasterizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package blr_pkg;

    localparam int COORD_BITS_DEF = 11;

    localparam int CFG_W       = 12;
    localparam int IN_COORD_W  = 16;
    localparam int OUT_COORD_W = 11;
    localparam int ADDR_W      = 22;
    localparam int COLOR_W     = 32;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 80;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

endpackage

`default_nettype wire

@@ rtl/bresenham_line_rasterizer_top.sv @@
// ----------------------------------------------------------------------------
// Bresenham line rasterizer
// Clamps line endpoints to the frame, steps one pixel per tick word and
// emits pixel coordinates, linear address, color and an endpoint flag.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tuser: operation; tdata: endpoints and color
//  m_axis    out        tlast: last pixel; tdata: x, y, address, color
//  cfg       in         frame width and height writes
//
//  One input word is accepted every cycle unless a stalled m_axis backs up;
//  each step is a single pass of clamp or Bresenham logic into the state
//  and a pixel register. A pixel then goes on to the m_axis output register;
//  the y * width + x address multiply lies between the two registers.
//  Reset is synchronous and active low; it leaves the rasterizer idle.
//  A stalled m_axis holds its word; one further pixel can still wait behind it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bresenham_line_rasterizer_top #(
    parameter int COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [blr_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [15:0] start_x, [31:16] start_y, [47:32] end_x_in, [63:48] end_y_in,
    // [95:64] color_in
    input  wire logic [blr_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] operation
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [10:0] pixel_x, [21:11] pixel_y, [43:22] pixel_address,
    // [75:44] pixel_color, [79:76] zero
    output logic [blr_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tlast
);
    import blr_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int ET_W = COORD_BITS + 2;
    localparam int LIM_W = IN_COORD_W + 1;
    localparam logic [LIM_W-1:0] COORD_MAX = LIM_W'((1 << COORD_BITS) - 1);
    localparam int PAD_W = M_TDATA_W - (2 * OUT_COORD_W + ADDR_W + COLOR_W);

    function automatic logic [CB-1:0] clamp_coord(input logic [IN_COORD_W-1:0] v,
                                                 input logic [CFG_W-1:0] size);
        logic [LIM_W-1:0] lim;
        lim = (size == '0) ? '0 : (LIM_W'(size) - LIM_W'(1));
        if (lim > COORD_MAX) begin
            lim = COORD_MAX;
        end
        clamp_coord = ({1'b0, v} > lim) ? lim[CB-1:0] : v[CB-1:0];
    endfunction

    logic [CFG_W-1:0]   fw_reg, fh_reg;

    logic [CB-1:0]      cur_x_reg, cur_y_reg, tgt_x_reg, tgt_y_reg;
    logic [CB-1:0]      dx_reg, dy_reg;
    logic               sxn_reg, syn_reg;
    logic signed [ET_W-1:0] err_reg;
    logic [COLOR_W-1:0] color_reg;
    logic               busy_reg;

    logic [CB-1:0]      cur_x_next, cur_y_next, tgt_x_next, tgt_y_next;
    logic [CB-1:0]      dx_next, dy_next;
    logic               sxn_next, syn_next;
    logic signed [ET_W-1:0] err_next;
    logic [COLOR_W-1:0] color_next;
    logic               busy_next;
    logic               res_valid;

    logic               a_valid_reg;
    logic [CB-1:0]      a_x_reg, a_y_reg;
    logic [COLOR_W-1:0] a_color_reg;
    logic               a_last_reg;

    logic               out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic               out_last_reg;

    logic               s_acc, advance_out;

    logic [CB-1:0]      x1, y1, x2, y2, sdx, sdy;
    logic signed [ET_W-1:0] e_cur, dx_s, dy_s;
    logic               move_x, move_y;
    logic [CB-1:0]      tick_x, tick_y;

    logic [CB+CFG_W-1:0] prod;
    logic [ADDR_W-1:0]   addr;

    assign advance_out = !out_valid_reg || m_tready;
    assign s_tready    = !a_valid_reg || advance_out;
    assign s_acc       = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= FRAME_WIDTH_RESET;
            fh_reg <= FRAME_HEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  fw_reg <= cfg_wdata;
                CFG_FRAME_HEIGHT: fh_reg <= cfg_wdata;
                default:          fw_reg <= fw_reg;
            endcase
        end
    end

    assign x1 = clamp_coord(s_tdata[15:0],  fw_reg);
    assign y1 = clamp_coord(s_tdata[31:16], fh_reg);
    assign x2 = clamp_coord(s_tdata[47:32], fw_reg);
    assign y2 = clamp_coord(s_tdata[63:48], fh_reg);
    assign sdx = (x2 > x1) ? (x2 - x1) : (x1 - x2);
    assign sdy = (y2 > y1) ? (y2 - y1) : (y1 - y2);

    assign e_cur  = err_reg;
    assign dx_s   = signed'({2'b00, dx_reg});
    assign dy_s   = signed'({2'b00, dy_reg});
    assign move_x = e_cur > -dx_s;
    assign move_y = e_cur < dy_s;
    assign tick_x = move_x ? (sxn_reg ? cur_x_reg - CB'(1) : cur_x_reg + CB'(1)) : cur_x_reg;
    assign tick_y = move_y ? (syn_reg ? cur_y_reg - CB'(1) : cur_y_reg + CB'(1)) : cur_y_reg;

    always_comb begin
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        tgt_x_next = tgt_x_reg;
        tgt_y_next = tgt_y_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        sxn_next   = sxn_reg;
        syn_next   = syn_reg;
        err_next   = err_reg;
        color_next = color_reg;
        busy_next  = busy_reg;
        res_valid  = 1'b0;
        unique case (s_tuser)
            OP_START: begin
                cur_x_next = x1;
                cur_y_next = y1;
                tgt_x_next = x2;
                tgt_y_next = y2;
                dx_next    = sdx;
                dy_next    = sdy;
                sxn_next   = !(x1 < x2);
                syn_next   = !(y1 < y2);
                err_next   = (sdx > sdy) ? signed'({3'b000, sdx[CB-1:1]})
                                         : -signed'({3'b000, sdy[CB-1:1]});
                color_next = s_tdata[95:64];
                busy_next  = !((x1 == x2) && (y1 == y2));
                res_valid  = 1'b1;
            end
            OP_TICK: begin
                if (busy_reg) begin
                    cur_x_next = tick_x;
                    cur_y_next = tick_y;
                    err_next   = e_cur - (move_x ? dy_s : '0) + (move_y ? dx_s : '0);
                    busy_next  = !((tick_x == tgt_x_reg) && (tick_y == tgt_y_reg));
                    res_valid  = 1'b1;
                end
            end
            default: res_valid = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (s_acc) begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            tgt_x_reg <= tgt_x_next;
            tgt_y_reg <= tgt_y_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            sxn_reg   <= sxn_next;
            syn_reg   <= syn_next;
            err_reg   <= err_next;
            color_reg <= color_next;
        end
    end

    // Pixel register: coordinates, color and endpoint flag of one result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_tready) begin
            a_valid_reg <= s_acc && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            a_x_reg     <= cur_x_next;
            a_y_reg     <= cur_y_next;
            a_color_reg <= color_next;
            a_last_reg  <= !busy_next;
        end
    end

    assign prod = a_y_reg * fw_reg;
    assign addr = ADDR_W'(prod) + ADDR_W'(a_x_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance_out) begin
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance_out && a_valid_reg) begin
            out_data_reg <= {PAD_W'(0), a_color_reg, addr,
                             OUT_COORD_W'(a_y_reg), OUT_COORD_W'(a_x_reg)};
            out_last_reg <= a_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

@@ rtl/blr_checker.sv @@
// ----------------------------------------------------------------------------
// Bresenham line rasterizer port checker
// Watches the stream ports of the rasterizer for pipeline timing slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bresenham_line_rasterizer_top_macros.svh"

module blr_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          cfg_we,
    input wire logic                          cfg_index,
    input wire logic [blr_pkg::CFG_W-1:0]     cfg_wdata,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [blr_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                          m_tlast
);
    import blr_pkg::*;

    logic start_acc;
    logic cfg_seen;

    assign start_acc = s_tvalid && s_tready && (s_tuser == OP_START);
    assign cfg_seen  = cfg_we && ((cfg_index == CFG_FRAME_WIDTH) || (cfg_wdata != '0));

    // Every start word brings m_tvalid high behind the pixel and output registers, or finds it held there.
    `BLR_ASSERT_SAME(a_start_yields_pixel, aclk, aresetn, start_acc, ##2 m_tvalid)

    // A new pixel word on an idle output only follows an accepted input word, through the pixel and output registers.
    `BLR_ASSERT_SAME(a_pixel_has_source, aclk, aresetn, $rose(m_tvalid),
        $past(s_tvalid && s_tready, 2))

    // With the output register empty, the input side is never stalled.
    `BLR_ASSERT_SAME(a_ready_when_drained, aclk, aresetn, !m_tvalid || cfg_seen,
        s_tready || m_tvalid)

    // A stalled pixel word holds its contents.
    `BLR_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind bresenham_line_rasterizer_top blr_checker u_blr_checker (.*);

`default_nettype wire

@@ test/tb_bresenham_line_rasterizer_top.sv @@
// ----------------------------------------------------------------------------
// Testbench for the Bresenham line rasterizer
// Drives start and tick words, directed first and then random line sequences
// under several frame sizes, with random sender gaps and receiver stalls.
// A scoreboard predicts every pixel word and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bresenham_line_rasterizer_top;
    import blr_pkg::*;

    localparam int COORD_MAX = (1 << OUT_COORD_W) - 1;

    class pixel_scoreboard;
        typedef struct {
            logic [OUT_COORD_W-1:0] x;
            logic [OUT_COORD_W-1:0] y;
            logic [ADDR_W-1:0]      addr;
            logic [COLOR_W-1:0]     color;
            logic                   last_flag;
        } pixel_t;

        pixel_t pending[$];
        int errors;
        int unsigned width_reg;
        int unsigned height_reg;
        logic [OUT_COORD_W-1:0] cur_x, cur_y, tgt_x, tgt_y;
        int delta_x, delta_y, err_term;
        bit neg_x, neg_y, busy;
        logic [COLOR_W-1:0] line_color;

        function new();
            width_reg  = 32'(FRAME_WIDTH_RESET);
            height_reg = 32'(FRAME_HEIGHT_RESET);
            cur_x = '0; cur_y = '0; tgt_x = '0; tgt_y = '0;
            delta_x = 0; delta_y = 0; err_term = 0;
            neg_x = 0; neg_y = 0; busy = 0;
            line_color = '0;
            errors = 0;
        endfunction

        function logic [OUT_COORD_W-1:0] clamp(logic [IN_COORD_W-1:0] v, int unsigned size);
            int unsigned lim;
            lim = (size == 0) ? 0 : size - 1;
            if (lim > COORD_MAX) lim = COORD_MAX;
            return (v > lim) ? lim[OUT_COORD_W-1:0] : v[OUT_COORD_W-1:0];
        endfunction

        function void write_reg(logic idx, logic [CFG_W-1:0] value);
            if (idx == CFG_FRAME_WIDTH) width_reg = 32'(value);
            else height_reg = 32'(value);
        endfunction

        function void push_pixel(bit last_flag);
            pixel_t p;
            p.x = cur_x;
            p.y = cur_y;
            p.addr = ADDR_W'(longint'(cur_y) * width_reg + cur_x);
            p.color = line_color;
            p.last_flag = last_flag;
            pending.push_back(p);
        endfunction

        function void note_word(logic op, logic [S_TDATA_W-1:0] data);
            logic [OUT_COORD_W-1:0] x1, y1, x2, y2;
            int e;
            if (op == OP_START) begin
                x1 = clamp(data[15:0], width_reg);
                y1 = clamp(data[31:16], height_reg);
                x2 = clamp(data[47:32], width_reg);
                y2 = clamp(data[63:48], height_reg);
                cur_x = x1; cur_y = y1; tgt_x = x2; tgt_y = y2;
                delta_x = (x2 > x1) ? int'(x2) - int'(x1) : int'(x1) - int'(x2);
                delta_y = (y2 > y1) ? int'(y2) - int'(y1) : int'(y1) - int'(y2);
                neg_x = !(x1 < x2);
                neg_y = !(y1 < y2);
                if (delta_x > delta_y) err_term = delta_x / 2;
                else err_term = -(delta_y / 2);
                line_color = data[95:64];
                busy = !(x1 == x2 && y1 == y2);
                push_pixel(!busy);
            end else if (busy) begin
                e = err_term;
                if (e > -delta_x) begin
                    err_term -= delta_y;
                    cur_x = neg_x ? cur_x - 1'b1 : cur_x + 1'b1;
                end
                if (e < delta_y) begin
                    err_term += delta_x;
                    cur_y = neg_y ? cur_y - 1'b1 : cur_y + 1'b1;
                end
                if (cur_x == tgt_x && cur_y == tgt_y) busy = 0;
                push_pixel(!busy);
            end
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(logic [M_TDATA_W-1:0] data, logic tlast);
            pixel_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected pixel word, expected none actual %h", $time, data);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare("pixel_x", 32'(want.x), 32'(data[10:0]));
            compare("pixel_y", 32'(want.y), 32'(data[21:11]));
            compare("pixel_address", 32'(want.addr), 32'(data[43:22]));
            compare("pixel_color", want.color, data[75:44]);
            compare("last_pixel", 32'(want.last_flag), 32'(tlast));
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_we;
    logic cfg_index;
    logic [CFG_W-1:0] cfg_wdata;
    logic s_tvalid;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tlast;

    pixel_scoreboard sb;
    int words_sent;
    int burst_left;
    bit gaps_on;
    int stall_mode;
    int stall_cnt;

    int ph_width[8]  = '{640, 1, 0, 4095, 2048, 2, 17, -1};
    int ph_height[8] = '{480, 1, 0, 4095, 2048, 2047, 5, -1};
    int ph_words[8]  = '{300, 60, 60, 200, 200, 150, 200, 300};
    int ph_span[8]   = '{12, 2, 2, 40, 30, 30, 8, 20};

    bresenham_line_rasterizer_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
            if (s_tvalid && s_tready) sb.note_word(s_tuser, s_tdata);
            if (m_tvalid && m_tready) sb.check_pixel(m_tdata, m_tlast);
        end
    end

    always @(negedge aclk) begin
        case (stall_mode)
            0: m_tready = 1'b1;
            1: m_tready = ($urandom_range(0, 3) != 0);
            2: begin
                m_tready = (stall_cnt % 7) < 4;
                stall_cnt++;
            end
            default: m_tready = ($urandom_range(0, 9) < 2);
        endcase
    end

    task automatic pause(int n);
        repeat (n) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
    endtask

    task automatic put_word(logic op, logic [15:0] sx, logic [15:0] sy,
                            logic [15:0] ex, logic [15:0] ey, logic [31:0] color);
        if (gaps_on && burst_left == 0) begin
            pause($urandom_range(1, 8));
            burst_left = $urandom_range(1, 24);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {color, ey, ex, sy, sx};
        do @(posedge aclk); while (!s_tready);
        if (burst_left > 0) burst_left--;
        words_sent++;
    endtask

    task automatic put_random_word(logic op);
        put_word(op, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
    endtask

    task automatic wait_for_pixels();
        pause(1);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [15:0] pick_coord(int unsigned size);
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, size + 1));
        endcase
    endfunction

    function automatic logic [15:0] near_coord(logic [15:0] v, int span);
        int t;
        t = int'(v) + int'($urandom_range(0, 2 * span)) - span;
        if (t < 0) t = 0;
        if (t > 65535) t = 65535;
        return 16'(t);
    endfunction

    task automatic run_phase(int n, int span);
        int target, len, ticks, ddx, ddy;
        logic [15:0] sx, sy, ex, ey;
        target = words_sent + n;
        // Ticks first, so a line left over from before the register write goes on.
        repeat ($urandom_range(0, 3)) put_random_word(OP_TICK);
        while (words_sent < target) begin
            if ($urandom_range(0, 9) < 8) begin
                sx = pick_coord(sb.width_reg);
                sy = pick_coord(sb.height_reg);
                if ($urandom_range(0, 3) == 0) begin
                    ex = pick_coord(sb.width_reg);
                    ey = pick_coord(sb.height_reg);
                end else begin
                    ex = near_coord(sx, span);
                    ey = near_coord(sy, span);
                end
                put_word(OP_START, sx, sy, ex, ey, $urandom);
                ddx = int'(sb.clamp(ex, sb.width_reg)) - int'(sb.clamp(sx, sb.width_reg));
                ddy = int'(sb.clamp(ey, sb.height_reg)) - int'(sb.clamp(sy, sb.height_reg));
                if (ddx < 0) ddx = -ddx;
                if (ddy < 0) ddy = -ddy;
                len = (ddx > ddy) ? ddx : ddy;
                case ($urandom_range(0, 19))
                    0, 1, 2: ticks = len + $urandom_range(1, 3);
                    3, 4, 5: ticks = (len > 0) ? $urandom_range(0, len - 1) : 0;
                    default: ticks = len;
                endcase
                for (int k = 0; k < ticks && words_sent < target; k++) begin
                    put_random_word(OP_TICK);
                end
            end else begin
                put_random_word(1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 60) == 0) wait_for_pixels();
        end
    endtask

    initial begin
        #2_000_000;
        $display("tb_bresenham_line_rasterizer_top NOT OK");
        $finish;
    end

    initial begin
        sb = new();
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_FRAME_WIDTH;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tuser    = OP_START;
        s_tdata    = '0;
        m_tready   = 1'b0;
        words_sent = 0;
        burst_left = 0;
        gaps_on    = 1'b0;
        stall_mode = 0;
        stall_cnt  = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed words at the reset frame size of 640 by 480.
        put_word(OP_TICK, 16'd5, 16'd5, 16'd9, 16'd9, 32'h1234_5678);
        put_word(OP_START, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0000_0000);
        put_word(OP_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        put_word(OP_START, 16'd0, 16'd0, 16'd5, 16'd2, 32'hA5A5_5A5A);
        repeat (5) put_word(OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        stall_mode = 1;
        put_word(OP_START, 16'd3, 16'd10, 16'd1, 16'd2, 32'h0F0F_F0F0);
        repeat (8) put_word(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0);
        put_word(OP_START, 16'd10, 16'd10, 16'd20, 16'd20, 32'hDEAD_BEEF);
        repeat (3) put_word(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0);
        put_word(OP_START, 16'd7, 16'd7, 16'd7, 16'd9, 32'h0000_0001);
        repeat (3) put_word(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0);
        wait_for_pixels();

        for (int p = 0; p < 8; p++) begin
            if (p > 0) begin
                write_reg(CFG_FRAME_WIDTH, (ph_width[p] < 0) ?
                          CFG_W'($urandom) : CFG_W'(ph_width[p]));
                write_reg(CFG_FRAME_HEIGHT, (ph_height[p] < 0) ?
                          CFG_W'($urandom) : CFG_W'(ph_height[p]));
            end
            stall_mode = p % 4;
            gaps_on    = (p % 3) != 1;
            burst_left = 0;
            run_phase(ph_words[p], ph_span[p]);
            wait_for_pixels();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_bresenham_line_rasterizer_top OK");
        end else begin
            if (sb.pending.size() != 0)
                $display("%0t: %0d pixel words never arrived", $time, sb.pending.size());
            $display("tb_bresenham_line_rasterizer_top NOT OK");
        end
        $finish;
    end
endmodule
